/* design/assert_macros.svh */
// Assertion macros shared by the palette search RTL.
// Define ASSERT_OFF to compile every assertion away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define NPCS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed in %m");
// Condition must never be true outside reset.
`define NPCS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `NPCS_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define NPCS_ASSERT(lbl, clk, rst_n, prop)
`define NPCS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* design/npcs_pkg.sv */
// Shared types and constants for the nearest palette color search.
// No dependencies; used by front end, command queue, back end and top level.
`default_nettype none

package npcs_pkg;

  localparam int unsigned COLOR_W = 8;   // one color channel
  localparam int unsigned IDX_W   = 8;   // palette index
  localparam int unsigned SPAN_W  = 9;   // scan bound, holds 256
  localparam int unsigned SQ_W    = 16;  // square of one channel difference
  localparam int unsigned DIST_W  = 18;  // sum of three squares, max 195075

  // Scan window when the system colors are skipped: [10, 246)
  localparam logic [SPAN_W-1:0] RESERVED_LOW = 9'd10;
  localparam logic [SPAN_W-1:0] RESERVED_END = 9'd246;

  // Stream payload layout
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 8;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_kind_e;

  // One classified command handed from front end to back end
  typedef struct packed {
    cmd_kind_e            kind;
    logic [IDX_W-1:0]     idx;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic [SPAN_W-1:0]    lo;
    logic [SPAN_W-1:0]    hi;
  } cmd_t;

endpackage

`default_nettype wire

/* design/nearest_palette_color_search.sv */
// Nearest palette color search: a palette of PALETTE_ENTRIES RGB entries is
// loaded by write transactions (tuser = 0, no result) and searched by query
// transactions (tuser = 1), which return the index of the entry with the
// smallest squared RGB distance, lowest index on ties. A query with
// skip_reserved set scans entries 10 to 245 only. The back end reads the
// palette memory through its single read port, one entry per clock, so a
// query occupies it for the whole scan. A two-entry command queue lets the
// input keep taking transactions while a scan runs or a result waits on the
// output. Query entries must have been written before.
// Depends on npcs_pkg, npcs_front, npcs_queue and npcs_back.
`default_nettype none

module nearest_palette_color_search #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue,
  // [32] skip_reserved, [39:33] zero
  input  wire logic [npcs_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] action
  input  wire logic                            s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [7:0] nearest_index
  output logic [npcs_pkg::M_TDATA_W-1:0]       m_axis_tdata_o
);

  npcs_pkg::cmd_t push_cmd, pop_cmd;
  logic q_push, q_pop, q_full, q_empty;

  npcs_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_front (
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  npcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (q_pop),
    .cmd_o   (pop_cmd)
  );

  npcs_back #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_cmd_i    (pop_cmd),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

/* design/npcs_front.sv */
// Front end: unpacks input transactions, classifies them and computes scan bounds.
// Depends on npcs_pkg; feeds npcs_queue.
`default_nettype none

module npcs_front #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic                            s_tvalid_i,
  output logic                                 s_tready_o,
  input  wire logic [npcs_pkg::S_TDATA_W-1:0]  s_tdata_i,
  input  wire logic                            s_tuser_i,
  input  wire logic                            q_full_i,
  output logic                                 q_push_o,
  output npcs_pkg::cmd_t                       q_cmd_o
);

  localparam logic [npcs_pkg::SPAN_W-1:0] ENTRIES_SPAN = npcs_pkg::SPAN_W'(PALETTE_ENTRIES);

  logic skip;
  logic in_range;

  // Unpack fields, lowest bits first
  always_comb begin
    q_cmd_o.kind  = npcs_pkg::cmd_kind_e'(s_tuser_i);
    q_cmd_o.idx   = s_tdata_i[7:0];
    q_cmd_o.red   = s_tdata_i[15:8];
    q_cmd_o.green = s_tdata_i[23:16];
    q_cmd_o.blue  = s_tdata_i[31:24];
    skip          = s_tdata_i[32];
    // Scan window for queries
    if (skip) begin
      q_cmd_o.lo = npcs_pkg::RESERVED_LOW;
      q_cmd_o.hi = npcs_pkg::RESERVED_END;
    end else begin
      q_cmd_o.lo = '0;
      q_cmd_o.hi = ENTRIES_SPAN;
    end
  end

  // Writes past the palette are taken and dropped here
  assign in_range   = ({1'b0, q_cmd_o.idx} < ENTRIES_SPAN);
  assign s_tready_o = !q_full_i;
  assign q_push_o   = s_tvalid_i && !q_full_i &&
                      ((q_cmd_o.kind == npcs_pkg::CMD_QUERY) || in_range);

endmodule

`default_nettype wire

/* design/npcs_queue.sv */
// Two-entry command queue between front end and back end.
// Depends on npcs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module npcs_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire npcs_pkg::cmd_t  cmd_i,
  output logic                 full_o,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output npcs_pkg::cmd_t       cmd_o
);

  npcs_pkg::cmd_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign cmd_o   = slot_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  `NPCS_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `NPCS_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o)
  `NPCS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= 2'd2)
  `NPCS_ASSERT(a_ptrs_match_count, clk_i, rst_ni,
               (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))

endmodule

`default_nettype wire

/* design/npcs_back.sv */
// Back end: palette memory, write execution and the pipelined nearest-entry scan.
// Depends on npcs_pkg and assert_macros.svh; drains npcs_queue.
`default_nettype none
`include "assert_macros.svh"

module npcs_back #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           q_empty_i,
  input  wire npcs_pkg::cmd_t                 q_cmd_i,
  output logic                                q_pop_o,
  output logic                                m_tvalid_o,
  input  wire logic                           m_tready_i,
  output logic [npcs_pkg::M_TDATA_W-1:0]      m_tdata_o
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CW = npcs_pkg::COLOR_W;
  localparam int unsigned SW = npcs_pkg::SPAN_W;
  localparam int unsigned QW = npcs_pkg::SQ_W;
  localparam int unsigned DW = npcs_pkg::DIST_W;
  localparam int unsigned IW = npcs_pkg::IDX_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } back_state_e;

  back_state_e state_q, state_d;

  logic [3*CW-1:0] pal_mem [PALETTE_ENTRIES];

  // Query color and scan control
  logic [CW-1:0] qr_q, qg_q, qb_q;
  logic          iss_q;
  logic [SW-1:0] addr_q, end_q;
  logic [SW-1:0] addr_inc;

  // Pipeline: memory read, squares, accumulate
  logic          rd_v_q;
  logic [IW-1:0] rd_idx_q;
  logic [3*CW-1:0] rd_data_q;
  logic          s1_v_q;
  logic [IW-1:0] s1_idx_q;
  logic [QW-1:0] sq_r_q, sq_g_q, sq_b_q;
  logic [CW-1:0] dr, dg, db;
  logic [DW-1:0] dist_sum;
  logic [DW-1:0] best_q;
  logic          first_q;
  logic [IW-1:0] pick_q;

  logic          out_v_q;
  logic [IW-1:0] out_data_q;

  logic pop_write, pop_query, scan_done, take_best;

  // Command dispatch
  always_comb begin
    q_pop_o   = 1'b0;
    pop_write = 1'b0;
    pop_query = 1'b0;
    scan_done = 1'b0;
    state_d   = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          if (q_cmd_i.kind == npcs_pkg::CMD_WRITE) begin
            pop_write = 1'b1;
          end else if (!out_v_q) begin
            pop_query = 1'b1;
            state_d   = ST_SCAN;
          end
        end
        q_pop_o = pop_write || pop_query;
      end
      ST_SCAN: begin
        if (!iss_q && !rd_v_q && !s1_v_q) begin
          scan_done = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign addr_inc = addr_q + SW'(1);

  // Palette memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (pop_write) begin
      pal_mem[q_cmd_i.idx[AW-1:0]] <= {q_cmd_i.blue, q_cmd_i.green, q_cmd_i.red};
    end
    if (iss_q) begin
      rd_data_q <= pal_mem[addr_q[AW-1:0]];
    end
  end

  // Channel distances of the entry just read
  always_comb begin
    dr = (qr_q >= rd_data_q[CW-1:0])      ? qr_q - rd_data_q[CW-1:0]
                                          : rd_data_q[CW-1:0] - qr_q;
    dg = (qg_q >= rd_data_q[2*CW-1:CW])   ? qg_q - rd_data_q[2*CW-1:CW]
                                          : rd_data_q[2*CW-1:CW] - qg_q;
    db = (qb_q >= rd_data_q[3*CW-1:2*CW]) ? qb_q - rd_data_q[3*CW-1:2*CW]
                                          : rd_data_q[3*CW-1:2*CW] - qb_q;
    dist_sum = DW'(sq_r_q) + DW'(sq_g_q) + DW'(sq_b_q);
    // Strictly smaller only, so the lowest index keeps a tie
    take_best = s1_v_q && (first_q || (dist_sum < best_q));
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop_query) begin
      qr_q <= q_cmd_i.red;
      qg_q <= q_cmd_i.green;
      qb_q <= q_cmd_i.blue;
      end_q <= q_cmd_i.hi;
    end
    rd_idx_q <= addr_q[IW-1:0];
    s1_idx_q <= rd_idx_q;
    sq_r_q   <= {{(QW-CW){1'b0}}, dr} * {{(QW-CW){1'b0}}, dr};
    sq_g_q   <= {{(QW-CW){1'b0}}, dg} * {{(QW-CW){1'b0}}, dg};
    sq_b_q   <= {{(QW-CW){1'b0}}, db} * {{(QW-CW){1'b0}}, db};
    if (take_best) begin
      best_q <= dist_sum;
      pick_q <= s1_idx_q;
    end
    if (scan_done) begin
      out_data_q <= pick_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iss_q   <= 1'b0;
      addr_q  <= '0;
      rd_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      first_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= iss_q;
      s1_v_q  <= rd_v_q;
      if (pop_query) begin
        iss_q   <= 1'b1;
        addr_q  <= q_cmd_i.lo;
        first_q <= 1'b1;
      end else if (iss_q) begin
        addr_q <= addr_inc;
        if (addr_inc == end_q) begin
          iss_q <= 1'b0;
        end
      end
      if (take_best) begin
        first_q <= 1'b0;
      end
      if (scan_done) begin
        out_v_q <= 1'b1;
      end else if (m_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_data_q;

  `NPCS_ASSERT(a_addr_in_window, clk_i, rst_ni, iss_q |-> (addr_q < end_q))
  `NPCS_ASSERT(a_query_needs_free_out, clk_i, rst_ni, pop_query |-> !out_v_q)
  `NPCS_ASSERT(a_pipe_only_in_scan, clk_i, rst_ni,
               (iss_q || rd_v_q || s1_v_q) |-> (state_q == ST_SCAN))
  `NPCS_ASSERT(a_done_sets_result, clk_i, rst_ni, scan_done |=> out_v_q)
  `NPCS_ASSERT_NEVER(a_first_entry_taken, clk_i, rst_ni, scan_done && first_q)

endmodule

`default_nettype wire

/* tb/nearest_palette_color_search_tb.sv */
// Self-checking testbench for nearest_palette_color_search: preloads the palette, then runs
// directed and random write/query traffic with bursty input and a stalling output.
// Depends on npcs_pkg and the nearest_palette_color_search RTL.
`default_nettype none

module nearest_palette_color_search_tb;

  localparam int unsigned PAL_ENTRIES  = 256;
  localparam int unsigned RANDOM_ITEMS = 1170;
  localparam int unsigned DRAIN_CYCLES = 300;

  // Palette shadow plus queue of expected nearest indexes
  class nearest_color_scoreboard;
    bit [23:0] palette [256];
    bit [7:0]  expected_nearest [$];
    int unsigned errors;

    function automatic bit [17:0] sq_dist(bit [7:0] a, bit [7:0] b);
      bit [17:0] d;
      d = (a >= b) ? 18'(a - b) : 18'(b - a);
      return d * d;
    endfunction

    // Ascending scan, strict compare keeps the lowest index on ties
    function automatic bit [7:0] nearest_entry(bit [7:0] r, bit [7:0] g, bit [7:0] b,
                                               bit skip);
      int unsigned lo;
      int unsigned hi;
      bit [18:0]   best;
      bit [17:0]   sum_sq;
      bit [7:0]    pick;
      lo   = skip ? int'(npcs_pkg::RESERVED_LOW) : 0;
      hi   = skip ? int'(npcs_pkg::RESERVED_END) : PAL_ENTRIES;
      if (hi > 256) hi = 256;
      best = '1;
      pick = 8'(lo);
      for (int unsigned i = lo; i < hi; i++) begin
        sum_sq = sq_dist(r, palette[i][7:0]) + sq_dist(g, palette[i][15:8]) +
                 sq_dist(b, palette[i][23:16]);
        if ({1'b0, sum_sq} < best) begin
          best = {1'b0, sum_sq};
          pick = 8'(i);
        end
      end
      return pick;
    endfunction

    // Accepted input transaction: update palette or queue the expected index
    function void note_transaction(npcs_pkg::cmd_kind_e kind,
                                   bit [npcs_pkg::S_TDATA_W-1:0] data);
      bit [7:0] idx;
      idx = data[7:0];
      if (kind == npcs_pkg::CMD_WRITE) begin
        if (idx < PAL_ENTRIES) palette[idx] = data[31:8];
      end else begin
        expected_nearest.push_back(nearest_entry(data[15:8], data[23:16], data[31:24],
                                                 data[32]));
      end
    endfunction

    // Accepted output transaction against the oldest expectation
    function void check_nearest(bit [7:0] got);
      bit [7:0] want;
      if (expected_nearest.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual nearest_index %0d",
                 $time, got);
        errors++;
        return;
      end
      want = expected_nearest.pop_front();
      if (got !== want) begin
        $display("%0t: nearest_index mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_nearest.size();
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_valid = 1'b0;
  logic [npcs_pkg::S_TDATA_W-1:0] s_data = '0;
  logic                           s_user = npcs_pkg::CMD_WRITE;
  logic                           m_ready = 1'b0;
  logic                           s_ready;
  logic                           m_valid;
  logic [npcs_pkg::M_TDATA_W-1:0] m_data;
  logic [11:0]                    rx_phase = '0;
  int unsigned                    burst_left = 0;

  nearest_color_scoreboard color_sb = new();

  nearest_palette_color_search #(
    .PALETTE_ENTRIES(PAL_ENTRIES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #6 clk_i = ~clk_i;

  // Receiver stall pattern: cycles through always-ready, coin flip, 1-in-4, mostly ready
  always @(negedge clk_i) begin
    rx_phase <= rx_phase + 1'b1;
    case (rx_phase[11:10])
      2'd0:    m_ready <= 1'b1;
      2'd1:    m_ready <= 1'($urandom_range(0, 1));
      2'd2:    m_ready <= (rx_phase[1:0] == 2'd0);
      default: m_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Monitor both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) color_sb.note_transaction(npcs_pkg::cmd_kind_e'(s_user), s_data);
      if (m_valid && m_ready) color_sb.check_nearest(m_data);
    end
  end

  // Present one transaction and hold it until accepted
  task automatic send_item(npcs_pkg::cmd_kind_e kind, bit [7:0] idx, bit [7:0] r,
                           bit [7:0] g, bit [7:0] b, bit skip);
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {7'd0, skip, b, g, r, idx};
    do @(posedge clk_i); while (!s_ready);
  endtask

  // Random burst/gap shaping ahead of each random transaction
  task automatic pace_sender();
    int unsigned gap;
    int unsigned sel;
    if (burst_left != 0) begin
      burst_left--;
      return;
    end
    sel = $urandom_range(0, 9);
    if (sel < 2)      gap = 0;
    else if (sel < 6) gap = $urandom_range(1, 4);
    else if (sel < 9) gap = $urandom_range(5, 40);
    else              gap = $urandom_range(100, 300);
    if (gap != 0) begin
      @(negedge clk_i);
      s_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    burst_left = $urandom_range(0, 20);
  endtask

  // Channel value biased toward extremes and a few repeats for ties
  function automatic bit [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd128;
      3:       return 8'($urandom_range(126, 129));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic bit [7:0] jitter(bit [7:0] v);
    int d;
    d = int'(v) + $urandom_range(0, 2) - 1;
    if (d < 0) d = 0;
    if (d > 255) d = 255;
    return 8'(d);
  endfunction

  initial begin
    bit [7:0]  idx;
    bit [23:0] col;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Preload every entry so no query reads an unwritten slot
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      col = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255))};
      if (i == 0)   col = 24'h000000;
      if (i == PAL_ENTRIES - 1) col = 24'hFFFFFF;
      if (i == 3 || i == 40 || i == 200) col = {8'd99, 8'd200, 8'd17};
      send_item(npcs_pkg::CMD_WRITE, 8'(i), col[7:0], col[15:8], col[23:16],
                1'($urandom_range(0, 1)));
    end

    // Directed: extremes, ties, reserved window edges, ignored fields
    send_item(npcs_pkg::CMD_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
    send_item(npcs_pkg::CMD_QUERY, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    send_item(npcs_pkg::CMD_QUERY, 8'd17,  8'd255, 8'd255, 8'd255, 1'b1);
    send_item(npcs_pkg::CMD_QUERY, 8'd200, 8'd0,   8'd0,   8'd0,   1'b1);
    send_item(npcs_pkg::CMD_QUERY, 8'd0,   8'd17,  8'd200, 8'd99,  1'b0);
    send_item(npcs_pkg::CMD_QUERY, 8'd0,   8'd17,  8'd200, 8'd99,  1'b1);
    send_item(npcs_pkg::CMD_WRITE, 8'd40,  8'd1,   8'd1,   8'd1,   1'b1);
    send_item(npcs_pkg::CMD_QUERY, 8'd0,   8'd17,  8'd200, 8'd99,  1'b1);
    send_item(npcs_pkg::CMD_QUERY, 8'd0,   8'd255, 8'd0,   8'd255, 1'b0);
    send_item(npcs_pkg::CMD_QUERY, 8'd0,   8'd0,   8'd255, 8'd0,   1'b1);
    send_item(npcs_pkg::CMD_WRITE, 8'd10,  8'd1,   8'd2,   8'd3,   1'b0);
    send_item(npcs_pkg::CMD_WRITE, 8'd245, 8'd1,   8'd2,   8'd3,   1'b0);
    send_item(npcs_pkg::CMD_QUERY, 8'd0,   8'd1,   8'd2,   8'd3,   1'b1);
    send_item(npcs_pkg::CMD_WRITE, 8'd10,  8'd250, 8'd250, 8'd0,   1'b0);
    send_item(npcs_pkg::CMD_QUERY, 8'd0,   8'd1,   8'd2,   8'd3,   1'b1);
    send_item(npcs_pkg::CMD_WRITE, 8'd9,   8'd77,  8'd1,   8'd250, 1'b0);
    send_item(npcs_pkg::CMD_WRITE, 8'd246, 8'd77,  8'd1,   8'd250, 1'b1);
    send_item(npcs_pkg::CMD_QUERY, 8'd0,   8'd77,  8'd1,   8'd250, 1'b1);
    send_item(npcs_pkg::CMD_QUERY, 8'd0,   8'd77,  8'd1,   8'd250, 1'b0);
    send_item(npcs_pkg::CMD_WRITE, 8'd128, 8'd128, 8'd128, 8'd128, 1'b1);
    send_item(npcs_pkg::CMD_QUERY, 8'd128, 8'd128, 8'd128, 8'd128, 1'b1);
    send_item(npcs_pkg::CMD_QUERY, 8'd255, 8'd127, 8'd129, 8'd128, 1'b0);

    // Random mix of writes and queries, queries often near existing entries
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pace_sender();
      if ($urandom_range(0, 99) < 55) begin
        case ($urandom_range(0, 5))
          0:       idx = 8'(npcs_pkg::RESERVED_LOW) - 8'($urandom_range(0, 1));
          1:       idx = 8'(npcs_pkg::RESERVED_END) - 8'($urandom_range(0, 1));
          default: idx = 8'($urandom_range(0, PAL_ENTRIES - 1));
        endcase
        send_item(npcs_pkg::CMD_WRITE, idx, pick_channel(), pick_channel(), pick_channel(),
                  1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          col = color_sb.palette[$urandom_range(0, PAL_ENTRIES - 1)];
          if ($urandom_range(0, 2) == 0)
            col = {jitter(col[23:16]), jitter(col[15:8]), jitter(col[7:0])};
        end else begin
          col = {pick_channel(), pick_channel(), pick_channel()};
        end
        send_item(npcs_pkg::CMD_QUERY, 8'($urandom_range(0, 255)), col[7:0], col[15:8],
                  col[23:16], 1'($urandom_range(0, 1)));
      end
    end

    // Drain outstanding results, then watch for stray output
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (color_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (color_sb.errors == 0) begin
      $display("nearest_palette_color_search test passed");
    end else begin
      $display("nearest_palette_color_search test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30000000;
    $display("nearest_palette_color_search test failed");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+design
design/npcs_pkg.sv
design/npcs_front.sv
design/npcs_queue.sv
design/npcs_back.sv
design/nearest_palette_color_search.sv
tb/nearest_palette_color_search_tb.sv
